// ===== rtl/core/gdfo_pkg.sv =====
// Shared types and constants of the depth-first order unit.
package gdfo_pkg;

  localparam int VERT_W           = 7;
  localparam int OP_W             = 2;
  localparam int CFG_IDX_W        = 2;
  localparam int MAX_VERTICES_DEF = 64;

  localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN      = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VERTICES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 2'd1;

  localparam logic [VERT_W-1:0] NUM_VERTICES_RST = 7'd64;
  localparam logic [VERT_W-1:0] START_VERTEX_RST = 7'd1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;
  } gdfo_in_t;

  typedef struct packed {
    logic [VERT_W-1:0] visited_vertex;
    logic              last;
  } gdfo_out_t;

endpackage

// ===== rtl/core/gdfo_adj_mem.sv =====
// Adjacency row memory with per-row valid bits and a registered read.
module gdfo_adj_mem import gdfo_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  localparam int IDX_W = $clog2(MAX_VERTICES)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  logic [IDX_W-1:0]        rd_addr_i,
  input  logic                    wr_en_i,
  input  logic [IDX_W-1:0]        wr_addr_i,
  input  logic [MAX_VERTICES-1:0] wr_data_i,
  output logic [MAX_VERTICES-1:0] rd_data_o
);

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] mem_rd_q;
  logic [MAX_VERTICES-1:0] row_vld_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    mem_rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= row_vld_q[rd_addr_i];
      if (clear_i) begin
        row_vld_q <= '0;
      end else if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? mem_rd_q : '0;

endmodule

// ===== rtl/core/gdfo_stack_ram.sv =====
// Walk stack storage: one write port, one registered read port.
module gdfo_stack_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 6,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

// ===== rtl/core/gdfo_pick.sv =====
// Lowest set bit search over the open-neighbour word, in groups of eight.
module gdfo_pick import gdfo_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  localparam int IDX_W = $clog2(MAX_VERTICES)
) (
  input  logic [MAX_VERTICES-1:0] open_i,
  output logic                    found_o,
  output logic [IDX_W-1:0]        idx_o
);

  localparam int GW    = 8;
  localparam int LOC_W = $clog2(GW);
  localparam int NG    = (MAX_VERTICES + GW - 1) / GW;
  localparam int PW    = NG * GW;

  logic [PW-1:0]     pad;
  logic [NG-1:0]     grp_any;
  logic [LOC_W-1:0]  grp_loc [NG];
  logic [VERT_W-1:0] idx_full;

  assign pad = PW'(open_i);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any[g] = |pad[g*GW +: GW];
      grp_loc[g] = '0;
      for (int b = GW - 1; b >= 0; b--) begin
        if (pad[g*GW + b]) begin
          grp_loc[g] = LOC_W'(b);
        end
      end
    end
  end

  always_comb begin
    idx_full = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        idx_full = VERT_W'(g * GW) + VERT_W'(grp_loc[g]);
      end
    end
  end

  assign found_o = |grp_any;
  assign idx_o   = idx_full[IDX_W-1:0];

endmodule

// ===== rtl/core/graph_depth_first_order_unit.sv =====
// Top level of the depth-first order unit: sequencer, configuration and output register.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  gdfo_in_t  (op, vertex_a, vertex_b)
//   out      output     out_valid_o/ out_stall_i gdfo_out_t (visited_vertex, last)
//   cfg      input      cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// Add edge makes two read-modify-write passes on the adjacency memory.
// Clear and unused ops leave the unit idle; clear drops all row valid bits at once.
// A run fetches the start row (row read, mask); each push then steps through pick, row read, mask
// and each pop through pick, stack read feeding the row read, mask; the final pop ends at the pick.
// Reset empties the graph at once; no clearing pass is needed.
// A stall on the output holds the walk at its next emission; input stalls while busy.
module graph_depth_first_order_unit import gdfo_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gdfo_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gdfo_out_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VERT_W-1:0]    cfg_wdata_i
);

  localparam int IDX_W   = $clog2(MAX_VERTICES);
  localparam int DEPTH_W = $clog2(MAX_VERTICES + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_A, ST_WR_A, ST_RD_B, ST_WR_B, ST_ROW, ST_OPEN, ST_PICK, ST_POP
  } state_e;

  state_e                  state_q;
  logic [VERT_W-1:0]       num_q, start_q;
  logic [MAX_VERTICES-1:0] visited_q, open_q;
  logic [DEPTH_W-1:0]      depth_q;
  logic [IDX_W-1:0]        top_q, pend_q, a_idx_q, b_idx_q;
  logic                    out_valid_q;
  gdfo_out_t               out_q;

  logic [VERT_W-1:0]       n_eff, a_m1, b_m1, s_m1;
  logic [MAX_VERTICES-1:0] act_mask;
  logic                    a_ok, b_ok, s_ok, accept, slot_free, emit;
  logic [IDX_W-1:0]        a_idx, b_idx, s_idx;

  logic [IDX_W-1:0]        adj_rd_addr, adj_wr_addr;
  logic                    adj_wr_en, adj_clear;
  logic [MAX_VERTICES-1:0] adj_wr_data, adj_rd_data;

  logic                    stk_wr_en;
  logic [IDX_W-1:0]        stk_wr_addr, stk_wr_data, stk_rd_addr, stk_rd_data;
  logic [DEPTH_W-1:0]      depth_m2;

  logic                    pick_found;
  logic [IDX_W-1:0]        pick_idx;
  logic [MAX_VERTICES-1:0] pick_hot, start_hot, a_hot, b_hot;

  assign n_eff = (num_q > VERT_W'(MAX_VERTICES)) ? VERT_W'(MAX_VERTICES) : num_q;

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      act_mask[j] = VERT_W'(j) < n_eff;
    end
  end

  assign a_m1  = in_data_i.vertex_a - VERT_W'(1);
  assign b_m1  = in_data_i.vertex_b - VERT_W'(1);
  assign s_m1  = start_q - VERT_W'(1);
  assign a_idx = a_m1[IDX_W-1:0];
  assign b_idx = b_m1[IDX_W-1:0];
  assign s_idx = s_m1[IDX_W-1:0];
  assign a_ok  = (in_data_i.vertex_a != '0) && (in_data_i.vertex_a <= n_eff);
  assign b_ok  = (in_data_i.vertex_b != '0) && (in_data_i.vertex_b <= n_eff);
  assign s_ok  = (start_q != '0) && (start_q <= n_eff);

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit      = (state_q == ST_PICK) && slot_free &&
                     (pick_found || (depth_q == DEPTH_W'(1)));

  assign pick_hot  = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << pick_idx;
  assign start_hot = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << s_idx;
  assign a_hot     = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_idx_q;
  assign b_hot     = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << b_idx_q;
  assign depth_m2  = depth_q - DEPTH_W'(2);

  always_comb begin
    adj_rd_addr = top_q;
    adj_wr_en   = 1'b0;
    adj_wr_addr = a_idx_q;
    adj_wr_data = adj_rd_data | b_hot;
    adj_clear   = accept && (in_data_i.op == OP_CLEAR);
    case (state_q)
      ST_RD_A: adj_rd_addr = a_idx_q;
      ST_RD_B: adj_rd_addr = b_idx_q;
      ST_POP:  adj_rd_addr = stk_rd_data;
      ST_WR_A: adj_wr_en   = 1'b1;
      ST_WR_B: begin
        adj_wr_en   = 1'b1;
        adj_wr_addr = b_idx_q;
        adj_wr_data = adj_rd_data | a_hot;
      end
      default: ;
    endcase
  end

  always_comb begin
    stk_wr_en   = 1'b0;
    stk_wr_addr = depth_q[IDX_W-1:0];
    stk_wr_data = pick_idx;
    stk_rd_addr = depth_m2[IDX_W-1:0];
    if (accept && (in_data_i.op == OP_RUN) && s_ok) begin
      stk_wr_en   = 1'b1;
      stk_wr_addr = '0;
      stk_wr_data = s_idx;
    end else if ((state_q == ST_PICK) && pick_found && slot_free) begin
      stk_wr_en = 1'b1;
    end
  end

  gdfo_adj_mem #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_adj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (adj_clear),
    .rd_addr_i(adj_rd_addr),
    .wr_en_i  (adj_wr_en),
    .wr_addr_i(adj_wr_addr),
    .wr_data_i(adj_wr_data),
    .rd_data_o(adj_rd_data)
  );

  gdfo_stack_ram #(
    .DEPTH(MAX_VERTICES),
    .WIDTH(IDX_W)
  ) u_stack (
    .clk_i    (clk_i),
    .wr_en_i  (stk_wr_en),
    .wr_addr_i(stk_wr_addr),
    .wr_data_i(stk_wr_data),
    .rd_addr_i(stk_rd_addr),
    .rd_data_o(stk_rd_data)
  );

  gdfo_pick #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_pick (
    .open_i (open_q),
    .found_o(pick_found),
    .idx_o  (pick_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_q       <= NUM_VERTICES_RST;
      start_q     <= START_VERTEX_RST;
      visited_q   <= '0;
      open_q      <= '0;
      depth_q     <= '0;
      top_q       <= '0;
      pend_q      <= '0;
      a_idx_q     <= '0;
      b_idx_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_NUM_VERTICES: num_q   <= cfg_wdata_i;
          CFG_START_VERTEX: start_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (in_data_i.op)
              OP_ADD_EDGE: begin
                if (a_ok && b_ok) begin
                  a_idx_q <= a_idx;
                  b_idx_q <= b_idx;
                  state_q <= ST_RD_A;
                end
              end
              OP_RUN: begin
                if (s_ok) begin
                  visited_q <= start_hot;
                  depth_q   <= DEPTH_W'(1);
                  top_q     <= s_idx;
                  pend_q    <= s_idx;
                  state_q   <= ST_ROW;
                end else begin
                  visited_q <= '0;
                  depth_q   <= '0;
                end
              end
              OP_CLEAR: begin
                visited_q <= '0;
                depth_q   <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_RD_A: state_q <= ST_WR_A;
        ST_WR_A: state_q <= ST_RD_B;
        ST_RD_B: state_q <= ST_WR_B;
        ST_WR_B: state_q <= ST_IDLE;
        ST_ROW:  state_q <= ST_OPEN;
        ST_OPEN: begin
          open_q  <= adj_rd_data & act_mask & ~visited_q;
          state_q <= ST_PICK;
        end
        ST_PICK: begin
          if (pick_found) begin
            if (slot_free) begin
              visited_q   <= visited_q | pick_hot;
              depth_q     <= depth_q + DEPTH_W'(1);
              top_q       <= pick_idx;
              pend_q      <= pick_idx;
              out_q       <= '{visited_vertex: VERT_W'(pend_q) + VERT_W'(1), last: 1'b0};
              state_q     <= ST_ROW;
            end
          end else if (depth_q == DEPTH_W'(1)) begin
            if (slot_free) begin
              depth_q     <= '0;
              out_q       <= '{visited_vertex: VERT_W'(pend_q) + VERT_W'(1), last: 1'b1};
              state_q     <= ST_IDLE;
            end
          end else begin
            depth_q <= depth_q - DEPTH_W'(1);
            state_q <= ST_POP;
          end
        end
        ST_POP: begin
          top_q   <= stk_rd_data;
          state_q <= ST_OPEN;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sim/gdfo_visit_order_checker.sv =====
`timescale 1ns / 100ps
// Checker of the depth-first order unit: watches all channels, predicts visit order, compares.
module gdfo_visit_order_checker import gdfo_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  gdfo_in_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  gdfo_out_t            out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VERT_W-1:0]    cfg_wdata_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  localparam int ROWS = MAX_VERTICES_DEF;

  logic [ROWS-1:0]   adj_rows [ROWS];
  logic [VERT_W-1:0] vertex_limit_q = NUM_VERTICES_RST;
  logic [VERT_W-1:0] walk_start_q   = START_VERTEX_RST;
  gdfo_out_t         visit_queue [$];
  gdfo_out_t         head_visit;
  int unsigned       mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic int unsigned active_count();
    return (vertex_limit_q > ROWS) ? ROWS : vertex_limit_q;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 50) $display("[%0t] visit check: %s", $time, what);
    mismatches++;
  endtask

  function automatic void add_edge(input logic [VERT_W-1:0] a, input logic [VERT_W-1:0] b);
    int unsigned n;
    n = active_count();
    if (a >= 1 && a <= n && b >= 1 && b <= n) begin
      adj_rows[a-1][b-1] = 1'b1;
      adj_rows[b-1][a-1] = 1'b1;
    end
  endfunction

  function automatic void predict_walk();
    logic [ROWS-1:0] seen;
    logic [ROWS-1:0] open_set;
    logic [ROWS-1:0] mask;
    logic [5:0]      trail [ROWS];
    int unsigned     n;
    int unsigned     s;
    int unsigned     depth;
    int unsigned     emitted;
    int unsigned     top;
    int unsigned     w;
    gdfo_out_t       visit;
    n = active_count();
    s = walk_start_q;
    if (s < 1 || s > n) return;
    mask = (n >= ROWS) ? '1 : ((ROWS'(1) << n) - 1'b1);
    seen = ROWS'(1) << (s - 1);
    trail[0] = 6'(s - 1);
    depth = 1;
    emitted = 1;
    visit.visited_vertex = VERT_W'(s);
    visit.last = 1'b0;
    visit_queue.push_back(visit);
    while (depth > 0) begin
      top = trail[depth-1];
      open_set = adj_rows[top] & mask & ~seen;
      if (open_set != '0 && depth < ROWS && emitted < ROWS) begin
        w = 0;
        while (!open_set[w]) w++;
        seen[w] = 1'b1;
        trail[depth] = 6'(w);
        depth++;
        visit.visited_vertex = VERT_W'(w + 1);
        visit_queue.push_back(visit);
        emitted++;
      end else begin
        depth--;
      end
    end
    visit = visit_queue.pop_back();
    visit.last = 1'b1;
    visit_queue.push_back(visit);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (adj_rows[r]) adj_rows[r] = '0;
      vertex_limit_q = NUM_VERTICES_RST;
      walk_start_q   = START_VERTEX_RST;
      visit_queue.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (visit_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected vertex %0d last %0b",
                                    out_data_i.visited_vertex, out_data_i.last));
        end else begin
          head_visit = visit_queue.pop_front();
          if (out_data_i.visited_vertex !== head_visit.visited_vertex)
            report_mismatch($sformatf("vertex %0d, predicted %0d",
                                      out_data_i.visited_vertex, head_visit.visited_vertex));
          if (out_data_i.last !== head_visit.last)
            report_mismatch($sformatf("last %0b on vertex %0d, predicted %0b",
                                      out_data_i.last, out_data_i.visited_vertex,
                                      head_visit.last));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_NUM_VERTICES: vertex_limit_q = cfg_wdata_i;
          CFG_START_VERTEX: walk_start_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.op)
          OP_ADD_EDGE: add_edge(in_data_i.vertex_a, in_data_i.vertex_b);
          OP_RUN:      predict_walk();
          OP_CLEAR:    foreach (adj_rows[r]) adj_rows[r] = '0;
          default: ;
        endcase
      end
    end
    pending_o    = visit_queue.size();
    fail_count_o = mismatches;
  end

endmodule

// ===== sim/graph_depth_first_order_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench top of the depth-first order unit: stimulus, idling, watchdog and verdict.
module graph_depth_first_order_unit_test;
  import gdfo_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int HOLDOFF_AFTER  = 60;
  localparam int ROUNDS         = 5;
  localparam int ROUND_ITEMS    = 38;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  gdfo_in_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  gdfo_out_t            out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_NUM_VERTICES;
  logic [VERT_W-1:0]    cfg_wdata_i = '0;

  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       items_taken   = 0;
  int unsigned       quiet_cycles  = 0;
  int unsigned       hold_left     = 0;
  bit                hold_done     = 1'b0;
  logic [VERT_W-1:0] cur_vertices  = NUM_VERTICES_RST;
  int unsigned       fail_count;
  int unsigned       pending;

  graph_depth_first_order_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  gdfo_visit_order_checker visit_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && out_valid_o && items_taken >= HOLDOFF_AFTER) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLDOFF_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) items_taken <= items_taken + 1;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [VERT_W-1:0] a,
                           input logic [VERT_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    in_data_i.op       <= op;
    in_data_i.vertex_a <= a;
    in_data_i.vertex_b <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [VERT_W-1:0] count, input logic [VERT_W-1:0] first);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_NUM_VERTICES;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_index_i <= CFG_START_VERTEX;
    cfg_wdata_i <= first;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    cur_vertices  = count;
  endtask

  task automatic send_random_item();
    int unsigned       pick;
    logic [VERT_W-1:0] span;
    pick = $urandom_range(99);
    span = (cur_vertices > MAX_VERTICES_DEF) ? VERT_W'(MAX_VERTICES_DEF) : cur_vertices;
    if (pick < 5)
      send_item(OP_CLEAR, VERT_W'($urandom_range(127)), VERT_W'($urandom_range(127)));
    else if (pick < 20)
      send_item(OP_RUN, VERT_W'($urandom_range(127)), VERT_W'($urandom_range(127)));
    else if (pick < 26)
      send_item(OP_UNUSED, VERT_W'($urandom_range(127)), VERT_W'($urandom_range(127)));
    else if (pick < 32 || span == 0)
      send_item(OP_ADD_EDGE, VERT_W'($urandom_range(127)), VERT_W'($urandom_range(127)));
    else
      send_item(OP_ADD_EDGE, VERT_W'($urandom_range(1, span)), VERT_W'($urandom_range(1, span)));
  endtask

  initial begin
    logic [VERT_W-1:0] count;
    logic [VERT_W-1:0] first;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_RUN, 7'd0, 7'd0);
    send_item(OP_UNUSED, 7'd127, 7'd127);
    send_item(OP_ADD_EDGE, 7'd1, 7'd64);
    send_item(OP_ADD_EDGE, 7'd64, 7'd2);
    send_item(OP_ADD_EDGE, 7'd2, 7'd2);
    send_item(OP_ADD_EDGE, 7'd64, 7'd1);
    send_item(OP_ADD_EDGE, 7'd0, 7'd5);
    send_item(OP_ADD_EDGE, 7'd65, 7'd1);
    send_item(OP_ADD_EDGE, 7'd3, 7'd127);
    send_item(OP_ADD_EDGE, 7'd1, 7'd3);
    send_item(OP_ADD_EDGE, 7'd3, 7'd5);
    send_item(OP_RUN, 7'd0, 7'd0);
    send_item(OP_CLEAR, 7'd127, 7'd127);
    send_item(OP_RUN, 7'd0, 7'd0);
    settle();
    set_config(7'd100, 7'd64);
    send_item(OP_ADD_EDGE, 7'd64, 7'd63);
    send_item(OP_ADD_EDGE, 7'd63, 7'd1);
    send_item(OP_RUN, 7'd0, 7'd0);
    settle();
    set_config(7'd0, 7'd1);
    send_item(OP_ADD_EDGE, 7'd1, 7'd1);
    send_item(OP_RUN, 7'd0, 7'd0);
    settle();
    set_config(7'd2, 7'd64);
    send_item(OP_RUN, 7'd0, 7'd0);
    settle();
    set_config(7'd2, 7'd1);
    send_item(OP_ADD_EDGE, 7'd1, 7'd2);
    send_item(OP_ADD_EDGE, 7'd2, 7'd63);
    send_item(OP_RUN, 7'd0, 7'd0);
    settle();
    set_config(7'd127, 7'd0);
    send_item(OP_RUN, 7'd0, 7'd0);
    settle();
    set_config(7'd64, 7'd63);
    send_item(OP_RUN, 7'd0, 7'd0);
    settle();

    for (int round = 0; round < ROUNDS; round++) begin
      if (round < 2) begin
        send_idle_pct = 30;
        recv_idle_pct = 56;
      end else if (round < 4) begin
        send_idle_pct = 56;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(3))
        0:       count = VERT_W'($urandom_range(2, 12));
        1:       count = VERT_W'($urandom_range(13, 63));
        2:       count = VERT_W'(MAX_VERTICES_DEF);
        default: count = VERT_W'($urandom_range(65, 127));
      endcase
      if ($urandom_range(7) == 0)
        first = VERT_W'($urandom_range(127));
      else
        first = VERT_W'($urandom_range(1, (count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : count));
      set_config(count, first);
      send_item(OP_CLEAR, VERT_W'($urandom_range(127)), VERT_W'($urandom_range(127)));
      repeat (ROUND_ITEMS) send_random_item();
      settle();
    end

    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
